// ===== src/palette16_color_blend_defines.svh =====
// Assertion macros for the palette blend block.
// No dependencies; taken in by the top level.
`ifndef PALETTE16_COLOR_BLEND_DEFINES_SVH
`define PALETTE16_COLOR_BLEND_DEFINES_SVH

// same-cycle implication
`define P16CB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p16cb check failed");

// next-cycle implication
`define P16CB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p16cb check failed");

`endif

// ===== src/p16cb_pkg.sv =====
// Types and constants shared by the palette blend block.
// No dependencies.
package p16cb_pkg;

  localparam int REG_COUNT  = 8;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int CFG_IDX_W  = 4;
  localparam int PAIR_W     = 48;
  localparam int ENTRY_W    = 24;
  localparam int CH_W       = 8;
  localparam int PROD_W     = 17;
  localparam int NOWRAP_SPAN = 239;
  localparam logic [7:0] BRI_OFF  = 8'd0;
  localparam logic [7:0] BRI_FULL = 8'd255;

  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_LINEAR     = 2'd1,
    MODE_NOWRAP     = 2'd2,
    MODE_LINEAR_ALT = 2'd3
  } mode_t;

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic       valid;
    logic       blend;
    logic [3:0] lo;
    logic       sel_a;
    logic       sel_b;
    logic [7:0] bri;
  } blend_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] bri;
  } scale_ctl_t;

endpackage

// ===== src/p16cb_palette.sv =====
// Palette store: eight 48-bit entry pairs, one write port, two registered reads.
// Depends on p16cb_pkg.
module p16cb_palette
  import p16cb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [REG_AW-1:0] wr_addr,
  input  logic [PAIR_W-1:0] wr_data,
  input  logic [REG_AW-1:0] rd_addr_a,
  input  logic [REG_AW-1:0] rd_addr_b,
  output logic [PAIR_W-1:0] rd_data_a,
  output logic [PAIR_W-1:0] rd_data_b
);

  logic [PAIR_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= filled[rd_addr_a] ? mem[rd_addr_a] : '0;
    rd_data_b <= filled[rd_addr_b] ? mem[rd_addr_b] : '0;
  end

endmodule

// ===== src/p16cb_blend.sv =====
// Blend stages: weighted products, then sum of the two scaled entries.
// Depends on p16cb_pkg.
module p16cb_blend
  import p16cb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  blend_ctl_t        ctl,
  input  logic [PAIR_W-1:0] pair_a,
  input  logic [PAIR_W-1:0] pair_b,
  output scale_ctl_t        out_ctl,
  output rgb_t              ch
);

  rgb_t                    e1, e2;
  logic [7:0]              f2;
  logic [8:0]              w1, w2;
  logic [2:0][PROD_W-1:0]  prod_a_next, prod_b_next;
  logic [2:0][PROD_W-1:0]  prod_a, prod_b;
  scale_ctl_t              mid_ctl;
  rgb_t                    ch_next;

  // no blend: weights 256 and 0 pass the entry through
  always_comb begin
    e1 = ctl.sel_a ? pair_a[PAIR_W-1:ENTRY_W] : pair_a[ENTRY_W-1:0];
    e2 = ctl.sel_b ? pair_b[PAIR_W-1:ENTRY_W] : pair_b[ENTRY_W-1:0];
    f2 = {ctl.lo, 4'b0000};
    w2 = ctl.blend ? 9'(f2) + 9'd1 : 9'd0;
    w1 = ctl.blend ? 9'd256 - 9'(f2) : 9'd256;
    for (int c = 0; c < 3; c++) begin
      prod_a_next[c] = PROD_W'(e1[c]) * PROD_W'(w1);
      prod_b_next[c] = PROD_W'(e2[c]) * PROD_W'(w2);
    end
  end

  always_ff @(posedge clk) begin
    prod_a <= prod_a_next;
    prod_b <= prod_b_next;
    if (rst) begin
      mid_ctl.valid <= 1'b0;
    end else begin
      mid_ctl <= '{valid: ctl.valid, bri: ctl.bri};
    end
  end

  // sum wraps at 8 bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_next[c] = prod_a[c][15:8] + prod_b[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    ch <= ch_next;
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl <= mid_ctl;
    end
  end

endmodule

// ===== src/p16cb_scale.sv =====
// Brightness stage and output register.
// Depends on p16cb_pkg.
module p16cb_scale
  import p16cb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scale_ctl_t ctl,
  input  rgb_t       ch,
  output logic       strobe,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic [8:0]             factor;
  logic [2:0][PROD_W-1:0] prod_next, prod;

  // off -> 0, full -> 256 (unity), else bri+2
  always_comb begin
    case (ctl.bri)
      BRI_OFF:  factor = 9'd0;
      BRI_FULL: factor = 9'd256;
      default:  factor = 9'(ctl.bri) + 9'd2;
    endcase
    for (int c = 0; c < 3; c++) begin
      prod_next[c] = PROD_W'(ch[c]) * PROD_W'(factor);
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.valid;
    end
  end

  assign red   = prod[2][15:8];
  assign green = prod[1][15:8];
  assign blue  = prod[0][15:8];

endmodule

// ===== src/palette16_color_blend.sv =====
// Top level of the sixteen-entry palette lookup with linear blend.
// Depends on p16cb_pkg, p16cb_palette, p16cb_blend, p16cb_scale and the defines header.
//
//   channel   handshake               payload
//   input     start / busy            color_index, brightness, mode
//   result    strobe (one cycle)      red, green, blue
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat per clock in while busy is low, one per clock out; the stages from accept
// to strobe are index remap, palette read, blend products, blend sum and brightness.
// Synchronous reset clears the palette valid bits and the stage valid bits;
// busy is high while reset is held and in the cycle after it is released, low otherwise.
// The receiver cannot stall; the pipeline never holds.
`include "palette16_color_blend_defines.svh"

module palette16_color_blend
  import p16cb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           color_index,
  input  logic [7:0]           brightness,
  input  logic [1:0]           mode,
  output logic                 strobe,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAIR_W-1:0]    cfg_data
);

  logic        accept;
  logic [15:0] remap_prod;
  logic [7:0]  idx_eff;

  logic       s1_valid;
  logic [3:0] s1_hi, s1_lo;
  logic       s1_blend;
  logic [7:0] s1_bri;
  logic [3:0] hi_adj;

  blend_ctl_t        s2_ctl;
  logic [PAIR_W-1:0] pair_a, pair_b;
  scale_ctl_t        s4_ctl;
  rgb_t              s4_ch;
  logic              wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT));

  // no-wrap remap: (index * 240) >> 8
  assign remap_prod = 16'(color_index) * 16'(NOWRAP_SPAN + 1);
  assign idx_eff    = (mode == MODE_NOWRAP) ? remap_prod[15:8] : color_index;

  always_ff @(posedge clk) begin
    s1_hi    <= idx_eff[7:4];
    s1_lo    <= idx_eff[3:0];
    s1_blend <= (mode != MODE_NONE) && (idx_eff[3:0] != 4'd0);
    s1_bri   <= brightness;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  assign hi_adj = s1_hi + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl <= '{valid: s1_valid, blend: s1_blend, lo: s1_lo,
                  sel_a: s1_hi[0], sel_b: hi_adj[0], bri: s1_bri};
    end
  end

  p16cb_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (cfg_index[REG_AW-1:0]),
    .wr_data   (cfg_data),
    .rd_addr_a (s1_hi[3:1]),
    .rd_addr_b (hi_adj[3:1]),
    .rd_data_a (pair_a),
    .rd_data_b (pair_b)
  );

  p16cb_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .ctl     (s2_ctl),
    .pair_a  (pair_a),
    .pair_b  (pair_b),
    .out_ctl (s4_ctl),
    .ch      (s4_ch)
  );

  p16cb_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .ctl    (s4_ctl),
    .ch     (s4_ch),
    .strobe (strobe),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

  `P16CB_ASSERT_NOW(a_latency, clk, rst, accept, ##5 strobe)
  `P16CB_ASSERT_NEXT(a_black, clk, rst,
    s4_ctl.valid && s4_ctl.bri == BRI_OFF,
    red == 8'd0 && green == 8'd0 && blue == 8'd0)
  `P16CB_ASSERT_NEXT(a_unity, clk, rst,
    s4_ctl.valid && s4_ctl.bri == BRI_FULL,
    red == $past(s4_ch[2]) && green == $past(s4_ch[1]) && blue == $past(s4_ch[0]))

endmodule
